/* src/sctod_pkg.sv */
package sctod_pkg;

    // Event kinds on the input channel
    typedef enum logic [1:0] {
        REQ_BYTE   = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_BUTTON = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    // ASCII codes used by the command parser and the reply formatter
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_W   = 8'h77;
    localparam logic [7:0] CH_UC_W   = 8'h57;
    localparam logic [7:0] CH_LC_H   = 8'h68;
    localparam logic [7:0] CH_LC_M   = 8'h6D;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UC_O   = 8'h4F;
    localparam logic [7:0] CH_UC_N   = 8'h4E;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY = 5'd24;

    // Reply request handed from the parser to the transmitter
    typedef struct packed {
        logic       valid;
        logic       is_alarm;
        logic       alarm_on;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_reply_req;

    // Two ASCII digits of a value in 0..63
    function automatic logic [15:0] two_digits(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] rest;
        if (v >= 6'd60)      tens = 3'd6;
        else if (v >= 6'd50) tens = 3'd5;
        else if (v >= 6'd40) tens = 3'd4;
        else if (v >= 6'd30) tens = 3'd3;
        else if (v >= 6'd20) tens = 3'd2;
        else if (v >= 6'd10) tens = 3'd1;
        else                 tens = 3'd0;
        rest = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
        return {CH_ZERO | {5'd0, tens}, CH_ZERO | {4'd0, rest[3:0]}};
    endfunction

endpackage

/* src/serial_commanded_time_of_day_clock_unit.sv */
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_req_type, i_rx_byte
// out     | output    | o_out_valid / i_out_stall  | o_tx_byte, o_last_char
//
// Every event passes through the input register, the parser and the state registers.
// A read command yields 8 (time), 11 (alarm ON) or 12 (alarm OFF) characters,
// sent one per cycle while the output is not stalled, from the reply serializer; a further read command waits
// at the input register until the serializer has handed out its last character.
// Synchronous active-low reset clears the parser, time, alarm and both channels.
// Output stall holds the output register; it backs up into the input only
// when a new reply is due.
module serial_commanded_time_of_day_clock_unit
    import sctod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_char
);

    t_reply_req reply;
    logic       tx_free;

    // Command parser and time keeping
    sctod_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_tx_free  (tx_free),
        .o_reply    (reply)
    );

    // Reply serializer
    sctod_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reply     (reply),
        .o_tx_free   (tx_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last_char (o_last_char)
    );

endmodule

/* src/sctod_core.sv */
module sctod_core
    import sctod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic       i_tx_free,
    output t_reply_req o_reply
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_OPEN  = 3'd1,
        ST_VERB  = 3'd2,
        ST_UNIT  = 3'd3,
        ST_TENS  = 3'd4,
        ST_DONE  = 3'd5,
        ST_SPARE6 = 3'd6,
        ST_SPARE7 = 3'd7
    } t_stage;

    // Input register
    logic       r_in_valid;
    t_req_type  r_req_type;
    logic [7:0] r_rx_byte;

    // Parser and clock state
    t_stage     r_stage, n_stage;
    logic       r_read_seen, n_read_seen;
    logic       r_want_time, n_want_time;
    logic       r_want_alarm, n_want_alarm;
    logic       r_wr_time, n_wr_time;
    logic       r_wr_alarm, n_wr_alarm;
    logic       r_u_hour, n_u_hour;
    logic       r_u_min, n_u_min;
    logic       r_u_sec, n_u_sec;
    logic       r_u_en, n_u_en;
    logic [7:0] r_tens, n_tens;
    logic [4:0] r_t_hour, n_t_hour;
    logic [5:0] r_t_min, n_t_min;
    logic [5:0] r_t_sec, n_t_sec;
    logic [4:0] r_a_hour, n_a_hour;
    logic [5:0] r_a_min, n_a_min;
    logic [5:0] r_a_sec, n_a_sec;
    logic       r_alarm_on, n_alarm_on;

    logic       is_byte;
    logic       is_digit;
    logic       reply_cmd;
    logic       fire;
    logic       hour_ok;
    logic       ms_ok;
    logic [6:0] pair_val;
    logic [5:0] sec_inc;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;

    assign is_byte   = (r_req_type == REQ_BYTE);
    assign is_digit  = (r_rx_byte >= CH_ZERO) && (r_rx_byte <= CH_NINE);
    assign reply_cmd = is_byte && (r_rx_byte == CH_RBRACK) && (r_stage == ST_UNIT)
                       && (r_want_time || r_want_alarm);
    assign fire       = r_in_valid && (!reply_cmd || i_tx_free);
    assign o_in_stall = r_in_valid && !fire;

    // Reply snapshot, taken before this item updates anything
    always_comb begin
        o_reply.valid    = fire && reply_cmd;
        o_reply.is_alarm = !r_want_time;
        o_reply.alarm_on = r_alarm_on;
        o_reply.hour     = r_want_time ? r_t_hour : r_a_hour;
        o_reply.minute   = r_want_time ? r_t_min  : r_a_min;
        o_reply.second   = r_want_time ? r_t_sec  : r_a_sec;
    end

    // Digit pair value and range checks
    assign pair_val = {r_tens[3:0], 3'b000} + {2'b00, r_tens[3:0], 1'b0}
                      + {3'b000, r_rx_byte[3:0]};
    assign hour_ok  = (r_tens <= CH_ONE) && (r_rx_byte <= CH_TWO);
    assign ms_ok    = (r_tens <= CH_FIVE) && (r_rx_byte <= CH_NINE);

    assign sec_inc  = r_t_sec + 6'd1;
    assign min_inc  = r_t_min + 6'd1;
    assign hour_inc = r_t_hour + 5'd1;

    // Next state for one event
    always_comb begin
        n_stage      = r_stage;
        n_read_seen  = r_read_seen;
        n_want_time  = r_want_time;
        n_want_alarm = r_want_alarm;
        n_wr_time    = r_wr_time;
        n_wr_alarm   = r_wr_alarm;
        n_u_hour     = r_u_hour;
        n_u_min      = r_u_min;
        n_u_sec      = r_u_sec;
        n_u_en       = r_u_en;
        n_tens       = r_tens;
        n_t_hour     = r_t_hour;
        n_t_min      = r_t_min;
        n_t_sec      = r_t_sec;
        n_a_hour     = r_a_hour;
        n_a_min      = r_a_min;
        n_a_sec      = r_a_sec;
        n_alarm_on   = r_alarm_on;

        unique case (r_req_type)
            REQ_BYTE: begin
                priority if (r_rx_byte == CH_LBRACK) begin
                    n_stage = ST_OPEN;
                end else if (r_rx_byte == CH_LC_R && r_stage == ST_OPEN) begin
                    n_stage = ST_VERB;
                    n_read_seen = 1'b1;
                end else if (r_rx_byte == CH_LC_T && r_stage == ST_VERB) begin
                    n_stage = ST_UNIT;
                    n_want_time = 1'b1;
                end else if (r_rx_byte == CH_LC_A && r_stage == ST_VERB && r_read_seen) begin
                    n_stage = ST_UNIT;
                    n_read_seen = 1'b0;
                    n_want_alarm = 1'b1;
                end else if (r_rx_byte == CH_RBRACK && r_stage == ST_UNIT) begin
                    n_stage = ST_IDLE;
                    if (r_want_time) begin
                        n_want_time = 1'b0;
                    end else if (r_want_alarm) begin
                        n_want_alarm = 1'b0;
                    end
                end else if (r_rx_byte == CH_LC_W && r_stage == ST_OPEN) begin
                    n_stage = ST_VERB;
                    n_wr_time = 1'b1;
                end else if (r_rx_byte == CH_UC_W && r_stage == ST_OPEN) begin
                    n_stage = ST_VERB;
                    n_wr_alarm = 1'b1;
                end else if (r_rx_byte == CH_LC_H && r_stage == ST_VERB) begin
                    n_stage = ST_UNIT;
                    n_u_hour = 1'b1;
                end else if (r_rx_byte == CH_LC_M && r_stage == ST_VERB) begin
                    n_stage = ST_UNIT;
                    n_u_min = 1'b1;
                end else if (r_rx_byte == CH_LC_S && r_stage == ST_VERB) begin
                    n_stage = ST_UNIT;
                    n_u_sec = 1'b1;
                end else if (r_rx_byte == CH_LC_A && r_stage == ST_VERB) begin
                    n_stage = ST_UNIT;
                    n_u_en = 1'b1;
                end else if (is_digit && r_stage == ST_UNIT) begin
                    n_tens = r_rx_byte;
                    n_stage = ST_TENS;
                end else if (is_digit && r_stage == ST_TENS) begin
                    n_stage = ST_DONE;
                    // first matching write wins; its flags are consumed
                    priority if (r_wr_time && r_u_hour) begin
                        n_wr_time = 1'b0;
                        n_u_hour = 1'b0;
                        if (hour_ok) n_t_hour = pair_val[4:0];
                    end else if (r_wr_time && r_u_min) begin
                        n_wr_time = 1'b0;
                        n_u_min = 1'b0;
                        if (ms_ok) n_t_min = pair_val[5:0];
                    end else if (r_wr_time && r_u_sec) begin
                        n_wr_time = 1'b0;
                        n_u_sec = 1'b0;
                        if (ms_ok) n_t_sec = pair_val[5:0];
                    end else if (r_wr_alarm && r_u_hour) begin
                        n_wr_alarm = 1'b0;
                        n_u_hour = 1'b0;
                        if (hour_ok) n_a_hour = pair_val[4:0];
                    end else if (r_wr_alarm && r_u_min) begin
                        n_wr_alarm = 1'b0;
                        n_u_min = 1'b0;
                        if (ms_ok) n_a_min = pair_val[5:0];
                    end else if (r_wr_alarm && r_u_sec) begin
                        n_wr_alarm = 1'b0;
                        n_u_sec = 1'b0;
                        if (ms_ok) n_a_sec = pair_val[5:0];
                    end else if (r_wr_alarm && r_u_en) begin
                        n_wr_alarm = 1'b0;
                        n_u_en = 1'b0;
                        n_alarm_on = !(r_tens == CH_ZERO && r_rx_byte == CH_ZERO);
                    end else begin
                        // digit pair with no pending write
                    end
                end else if (r_rx_byte == CH_RBRACK && r_stage == ST_DONE) begin
                    n_stage = ST_IDLE;
                end else begin
                    // byte ignored
                end
            end
            REQ_TICK: begin
                // seconds, minutes, hours roll at 60/60/24
                if (sec_inc >= SEC_PER_MIN) begin
                    n_t_sec = 6'd0;
                    if (min_inc >= MIN_PER_HOUR) begin
                        n_t_min = 6'd0;
                        n_t_hour = (hour_inc >= HOUR_PER_DAY) ? 5'd0 : hour_inc;
                    end else begin
                        n_t_min = min_inc;
                    end
                end else begin
                    n_t_sec = sec_inc;
                end
            end
            REQ_BUTTON: begin
                n_alarm_on = !r_alarm_on;
            end
            REQ_NONE: begin
                // unused event kind
            end
            default: begin
            end
        endcase
    end

    // Input register and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_stage      <= ST_IDLE;
            r_read_seen  <= 1'b0;
            r_want_time  <= 1'b0;
            r_want_alarm <= 1'b0;
            r_wr_time    <= 1'b0;
            r_wr_alarm   <= 1'b0;
            r_u_hour     <= 1'b0;
            r_u_min      <= 1'b0;
            r_u_sec      <= 1'b0;
            r_u_en       <= 1'b0;
            r_tens       <= 8'd0;
            r_t_hour     <= 5'd0;
            r_t_min      <= 6'd0;
            r_t_sec      <= 6'd0;
            r_a_hour     <= 5'd0;
            r_a_min      <= 6'd0;
            r_a_sec      <= 6'd0;
            r_alarm_on   <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_req_type <= t_req_type'(i_req_type);
                    r_rx_byte  <= i_rx_byte;
                end
            end
            if (fire) begin
                r_stage      <= n_stage;
                r_read_seen  <= n_read_seen;
                r_want_time  <= n_want_time;
                r_want_alarm <= n_want_alarm;
                r_wr_time    <= n_wr_time;
                r_wr_alarm   <= n_wr_alarm;
                r_u_hour     <= n_u_hour;
                r_u_min      <= n_u_min;
                r_u_sec      <= n_u_sec;
                r_u_en       <= n_u_en;
                r_tens       <= n_tens;
                r_t_hour     <= n_t_hour;
                r_t_min      <= n_t_min;
                r_t_sec      <= n_t_sec;
                r_a_hour     <= n_a_hour;
                r_a_min      <= n_a_min;
                r_a_sec      <= n_a_sec;
                r_alarm_on   <= n_alarm_on;
            end
        end
    end

endmodule

/* src/sctod_tx.sv */
module sctod_tx
    import sctod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_reply_req i_reply,
    output logic       o_tx_free,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_char
);

    // Reply snapshot and character index
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_is_alarm;
    logic       r_on;
    logic [4:0] r_hour;
    logic [5:0] r_min;
    logic [5:0] r_sec;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       slot_open;
    logic       emit;
    logic [7:0] cur_char;
    logic       cur_last;
    logic [15:0] hh;
    logic [15:0] mm;
    logic [15:0] ss;

    assign slot_open = !r_out_valid || !i_out_stall;
    assign emit      = r_busy && slot_open;
    assign o_tx_free = !r_busy || (emit && cur_last);

    assign hh = two_digits({1'b0, r_hour});
    assign mm = two_digits(r_min);
    assign ss = two_digits(r_sec);

    // Character at the current index: HH:MM:SS, then for an alarm reply " ON" or " OFF"
    always_comb begin
        cur_last = 1'b0;
        unique case (r_idx)
            4'd0:    cur_char = hh[15:8];
            4'd1:    cur_char = hh[7:0];
            4'd2:    cur_char = CH_COLON;
            4'd3:    cur_char = mm[15:8];
            4'd4:    cur_char = mm[7:0];
            4'd5:    cur_char = CH_COLON;
            4'd6:    cur_char = ss[15:8];
            4'd7: begin
                cur_char = ss[7:0];
                cur_last = !r_is_alarm;
            end
            4'd8:    cur_char = CH_SPACE;
            4'd9:    cur_char = CH_UC_O;
            4'd10: begin
                cur_char = r_on ? CH_UC_N : CH_UC_F;
                cur_last = r_on;
            end
            4'd11: begin
                cur_char = CH_UC_F;
                cur_last = 1'b1;
            end
            default: begin
                cur_char = CH_UC_F;
                cur_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            // serializer walks the snapshot one character per transfer slot
            if (i_reply.valid) begin
                r_busy     <= 1'b1;
                r_idx      <= 4'd0;
                r_is_alarm <= i_reply.is_alarm;
                r_on       <= i_reply.alarm_on;
                r_hour     <= i_reply.hour;
                r_min      <= i_reply.minute;
                r_sec      <= i_reply.second;
            end else if (emit) begin
                if (cur_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
            // output register
            if (slot_open) begin
                r_out_valid <= emit;
                if (emit) begin
                    r_out_byte <= cur_char;
                    r_out_last <= cur_last;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last_char = r_out_last;

endmodule

/* src/sctod_checker.sv */
module sctod_checker
    import sctod_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_req_type,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_tx_byte,
    input logic       o_last_char
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_byte)
            && $stable(o_last_char))
        else $error("stalled character changed");

    // a reply streams without gaps until its last character
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_char |=> o_out_valid)
        else $error("gap inside a reply");

    // a reply ends on a seconds digit, 'N' or 'F'
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_char |->
            ((o_tx_byte >= CH_ZERO && o_tx_byte <= CH_NINE)
             || o_tx_byte == CH_UC_N || o_tx_byte == CH_UC_F))
        else $error("bad final character");

endmodule

bind serial_commanded_time_of_day_clock_unit sctod_checker u_sctod_checker (.*);

/* bench/tb_serial_commanded_time_of_day_clock_unit.sv */
`timescale 1ns / 100ps

import sctod_pkg::*;

// Parser position, one step per command byte
typedef enum logic [2:0] {
    P_IDLE,
    P_OPEN,
    P_VERB,
    P_UNIT,
    P_TENS,
    P_DONE
} t_parse_state;

// One reply character as it should leave the block
typedef struct packed {
    logic [7:0] ch;
    logic       last;
} t_reply_char;

// Clock/parser shadow plus the queue of reply characters still owed
class tod_scoreboard;
    t_parse_state stage = P_IDLE;
    bit read_seen;
    bit want_time;
    bit want_alarm;
    bit wr_time;
    bit wr_alarm;
    bit unit_hour;
    bit unit_min;
    bit unit_sec;
    bit unit_en;
    logic [7:0] tens = '0;
    logic [4:0] tod_hour = '0;
    logic [5:0] tod_min = '0;
    logic [5:0] tod_sec = '0;
    logic [4:0] al_hour = '0;
    logic [5:0] al_min = '0;
    logic [5:0] al_sec = '0;
    bit al_on;
    t_reply_char replies[$];
    int n_errors;

    function void push_char(logic [7:0] c);
        replies.push_back('{ch: c, last: 1'b0});
    endfunction

    function void push_two(int v);
        v = v % 100;
        push_char(CH_ZERO + 8'(v / 10));
        push_char(CH_ZERO + 8'(v % 10));
    endfunction

    // HH:MM:SS
    function void push_hms(int h, int m, int s);
        push_two(h);
        push_char(CH_COLON);
        push_two(m);
        push_char(CH_COLON);
        push_two(s);
    endfunction

    // Second digit of a write: first matching mode/unit pair wins
    function void apply_write(logic [7:0] u);
        bit hour_ok;
        bit ms_ok;
        int val;
        hour_ok = (tens <= CH_ONE) && (u <= CH_TWO);
        ms_ok = (tens <= CH_FIVE) && (u <= CH_NINE);
        val = (int'(tens) - int'(CH_ZERO)) * 10 + int'(u) - int'(CH_ZERO);
        if (wr_time && unit_hour) begin
            wr_time = 0;
            unit_hour = 0;
            if (hour_ok) tod_hour = 5'(val);
        end else if (wr_time && unit_min) begin
            wr_time = 0;
            unit_min = 0;
            if (ms_ok) tod_min = 6'(val);
        end else if (wr_time && unit_sec) begin
            wr_time = 0;
            unit_sec = 0;
            if (ms_ok) tod_sec = 6'(val);
        end else if (wr_alarm && unit_hour) begin
            wr_alarm = 0;
            unit_hour = 0;
            if (hour_ok) al_hour = 5'(val);
        end else if (wr_alarm && unit_min) begin
            wr_alarm = 0;
            unit_min = 0;
            if (ms_ok) al_min = 6'(val);
        end else if (wr_alarm && unit_sec) begin
            wr_alarm = 0;
            unit_sec = 0;
            if (ms_ok) al_sec = 6'(val);
        end else if (wr_alarm && unit_en) begin
            wr_alarm = 0;
            unit_en = 0;
            al_on = !(tens == CH_ZERO && u == CH_ZERO);
        end
    endfunction

    function void take_byte(logic [7:0] c);
        int n0;
        bit digit;
        n0 = replies.size();
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_LBRACK) begin
            stage = P_OPEN;
        end else if (c == CH_LC_R && stage == P_OPEN) begin
            stage = P_VERB;
            read_seen = 1;
        end else if (c == CH_LC_T && stage == P_VERB) begin
            stage = P_UNIT;
            want_time = 1;
        end else if (c == CH_LC_A && stage == P_VERB && read_seen) begin
            stage = P_UNIT;
            read_seen = 0;
            want_alarm = 1;
        end else if (c == CH_RBRACK && stage == P_UNIT) begin
            stage = P_IDLE;
            if (want_time) begin
                push_hms(int'(tod_hour), int'(tod_min), int'(tod_sec));
                want_time = 0;
            end else if (want_alarm) begin
                push_hms(int'(al_hour), int'(al_min), int'(al_sec));
                push_char(CH_SPACE);
                push_char(CH_UC_O);
                if (al_on) begin
                    push_char(CH_UC_N);
                end else begin
                    push_char(CH_UC_F);
                    push_char(CH_UC_F);
                end
                want_alarm = 0;
            end
            if (replies.size() > n0) replies[replies.size() - 1].last = 1'b1;
        end else if (c == CH_LC_W && stage == P_OPEN) begin
            stage = P_VERB;
            wr_time = 1;
        end else if (c == CH_UC_W && stage == P_OPEN) begin
            stage = P_VERB;
            wr_alarm = 1;
        end else if (c == CH_LC_H && stage == P_VERB) begin
            stage = P_UNIT;
            unit_hour = 1;
        end else if (c == CH_LC_M && stage == P_VERB) begin
            stage = P_UNIT;
            unit_min = 1;
        end else if (c == CH_LC_S && stage == P_VERB) begin
            stage = P_UNIT;
            unit_sec = 1;
        end else if (c == CH_LC_A && stage == P_VERB) begin
            stage = P_UNIT;
            unit_en = 1;
        end else if (digit && stage == P_UNIT) begin
            tens = c;
            stage = P_TENS;
        end else if (digit && stage == P_TENS) begin
            stage = P_DONE;
            apply_write(c);
        end else if (c == CH_RBRACK && stage == P_DONE) begin
            stage = P_IDLE;
        end
    endfunction

    // One-second tick, 60/60/24 rollover
    function void advance();
        tod_sec = tod_sec + 6'd1;
        if (tod_sec >= SEC_PER_MIN) begin
            tod_sec = '0;
            tod_min = tod_min + 6'd1;
            if (tod_min >= MIN_PER_HOUR) begin
                tod_min = '0;
                tod_hour = tod_hour + 5'd1;
                if (tod_hour >= HOUR_PER_DAY) tod_hour = '0;
            end
        end
    endfunction

    // Called once per accepted input transfer
    function void note_transfer(t_req_type kind, logic [7:0] c);
        case (kind)
            REQ_BYTE:   take_byte(c);
            REQ_TICK:   advance();
            REQ_BUTTON: al_on = !al_on;
            default:    ;
        endcase
    endfunction

    // Called once per accepted output transfer
    function void check_char(logic [7:0] tx, logic last);
        t_reply_char e;
        if (replies.size() == 0) begin
            $error("unexpected reply: tx_byte %h last_char %b", tx, last);
            n_errors++;
            return;
        end
        e = replies.pop_front();
        if (tx !== e.ch) begin
            $error("tx_byte: expected %h, actual %h", e.ch, tx);
            n_errors++;
        end
        if (last !== e.last) begin
            $error("last_char: expected %b, actual %b", e.last, last);
            n_errors++;
        end
    endfunction

    function int pending();
        return replies.size();
    endfunction
endclass

module tb_serial_commanded_time_of_day_clock_unit;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS = 35;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_req_type  i_req_type = REQ_BYTE;
    logic [7:0] i_rx_byte = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_tx_byte;
    logic       o_last_char;

    tod_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int sent_count = 0;

    serial_commanded_time_of_day_clock_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last_char (o_last_char)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Reply checking and watchdog on transfers in either direction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_char(o_tx_byte, o_last_char);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the transfer happens
    task automatic send_item(t_req_type kind, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_transfer(kind, b);
        if (kind != REQ_NONE) sent_count++;
    endtask

    // Command text packed first byte highest, len bytes at the low end
    task automatic send_cmd(logic [47:0] text, int len);
        for (int i = 0; i < len; i++) send_item(REQ_BYTE, text[8 * (len - 1 - i) +: 8]);
    endtask

    // Stop offering and wait for every owed reply character
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Mostly well-formed commands with random content, some noise and fragments
    task automatic rand_command();
        int sel;
        int len;
        logic [7:0] verb;
        logic [7:0] target;
        logic [7:0] unit_ch;
        logic [7:0] tens;
        logic [7:0] ones;
        logic [7:0] stray;
        logic [47:0] text;
        sel = $urandom_range(99);
        verb = ($urandom_range(1) == 0) ? CH_LC_W : CH_UC_W;
        case ($urandom_range(3))
            0:       unit_ch = CH_LC_H;
            1:       unit_ch = CH_LC_M;
            2:       unit_ch = CH_LC_S;
            default: unit_ch = CH_LC_A;
        endcase
        if (unit_ch == CH_LC_H) begin
            tens = CH_ZERO + 8'($urandom_range(1));
            ones = CH_ZERO + 8'($urandom_range(2));
        end else if (unit_ch == CH_LC_A) begin
            tens = ($urandom_range(1) == 0) ? CH_ZERO : CH_ZERO + 8'($urandom_range(9));
            ones = ($urandom_range(1) == 0) ? CH_ZERO : CH_ZERO + 8'($urandom_range(9));
        end else begin
            tens = CH_ZERO + 8'($urandom_range(5));
            ones = CH_ZERO + 8'($urandom_range(9));
        end
        // some values out of range so the write is dropped
        if ($urandom_range(4) == 0) begin
            tens = CH_ZERO + 8'($urandom_range(9));
            ones = CH_ZERO + 8'($urandom_range(9));
        end
        text = {CH_LBRACK, verb, unit_ch, tens, ones, CH_RBRACK};
        if (sel < 25) begin
            verb = ($urandom_range(7) == 0) ? CH_LC_W : CH_LC_R;
            target = ($urandom_range(1) == 0) ? CH_LC_T : CH_LC_A;
            send_cmd(48'({CH_LBRACK, verb, target, CH_RBRACK}), 4);
        end else if (sel < 55) begin
            send_cmd(text, 6);
        end else if (sel < 70) begin
            repeat ($urandom_range(1, 4)) send_item(REQ_TICK, 8'($urandom_range(255)));
        end else if (sel < 76) begin
            send_item(REQ_BUTTON, 8'($urandom_range(255)));
        end else if (sel < 88) begin
            send_item(t_req_type'($urandom_range(3)), 8'($urandom_range(255)));
        end else begin
            // cut-off write followed by a stray byte
            len = $urandom_range(1, 5);
            send_cmd(text >> (8 * (6 - len)), len);
            case ($urandom_range(2))
                0:       stray = CH_LBRACK;
                1:       stray = CH_RBRACK;
                default: stray = 8'($urandom_range(255));
            endcase
            send_item(REQ_BYTE, stray);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_chance, int n);
        int goal;
        send_idle_pct = idle_pct;
        stall_pct = stall_chance;
        goal = sent_count + n;
        while (sent_count < goal) rand_command();
        drain();
    endtask

    initial begin
        sb = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, unused request kind
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_NONE, 8'hA5);
        // write prefix followed by 't' still reads the time
        send_cmd(48'({CH_LBRACK, CH_LC_W, CH_LC_T, CH_RBRACK}), 4);
        send_item(REQ_BUTTON, 8'h00);
        send_cmd(48'({CH_LBRACK, CH_LC_R, CH_LC_A, CH_RBRACK}), 4);
        send_item(REQ_TICK, 8'hFF);
        // digits after a read: nothing written, want_time left stale
        send_cmd({CH_LBRACK, CH_LC_R, CH_LC_T, CH_ONE, CH_TWO, CH_RBRACK}, 6);
        // stale flag turns an alarm read into a time read
        send_cmd(48'({CH_LBRACK, CH_LC_R, CH_LC_A, CH_RBRACK}), 4);
        drain();

        // Carry seconds into minutes and hours
        send_cmd({CH_LBRACK, CH_LC_W, CH_LC_H, CH_ONE, CH_TWO, CH_RBRACK}, 6);
        send_cmd({CH_LBRACK, CH_LC_W, CH_LC_M, CH_FIVE, CH_NINE, CH_RBRACK}, 6);
        send_cmd({CH_LBRACK, CH_LC_W, CH_LC_S, CH_FIVE, CH_ZERO, CH_RBRACK}, 6);
        repeat (12) send_item(REQ_TICK, 8'($urandom_range(255)));
        send_cmd(48'({CH_LBRACK, CH_LC_R, CH_LC_T, CH_RBRACK}), 4);
        drain();

        // Random traffic under each idling pattern
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(87, 0, PHASE_ITEMS);

        // Long receiver hold-off while reads keep coming
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 400;
        repeat (6) begin
            send_cmd(48'({CH_LBRACK, CH_LC_R, CH_LC_T, CH_RBRACK}), 4);
            send_item(REQ_TICK, 8'($urandom_range(255)));
        end
        drain();

        run_phase(0, 87, PHASE_ITEMS);
        run_phase(17, 17, PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
